### rtl/gsh_pkg.sv
`timescale 1ns / 1ps

package gsh_pkg;

  // Predictor geometry
  localparam int TABLE_ENTRIES = 4096;
  localparam int COUNTER_BITS  = 2;
  localparam int THREADS       = 4;
  localparam int INST_SHIFT    = 2;
  localparam int LINE_SHIFT    = 6;

  // Widths, the first two derived from the geometry
  localparam int HIST_BITS   = $clog2(TABLE_ENTRIES);
  localparam int TID_BITS    = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int PC_BITS     = 48;
  localparam int THREAD_BITS = 2;
  localparam int SNAP_BITS   = 12;
  localparam int REQ_BITS    = 3;

  typedef logic [HIST_BITS-1:0]    hist_t;
  typedef logic [TID_BITS-1:0]     tid_t;
  typedef logic [COUNTER_BITS-1:0] ctr_t;

  // Counter limits: saturate at all ones, predict taken above half scale
  localparam ctr_t CTR_MAX    = '1;
  localparam ctr_t CTR_THRESH = ctr_t'((1 << (COUNTER_BITS - 1)) - 1);

  typedef enum logic [REQ_BITS-1:0] {
    REQ_LOOKUP  = 3'd0,
    REQ_SHIFT   = 3'd1,
    REQ_RESTORE = 3'd2,
    REQ_COMMIT  = 3'd3,
    REQ_REPAIR  = 3'd4
  } req_kind_t;

  // History update issued as an item leaves the first stage
  typedef struct packed {
    logic      en;
    req_kind_t kind;
    tid_t      tid;
    logic      odd;
    logic      taken;
    hist_t     sg;
    hist_t     sgi;
    logic      sodd;
  } hist_upd_t;

  // Counter write-back
  typedef struct packed {
    logic  en;
    hist_t idx;
    ctr_t  data;
  } ctr_wr_t;

  // Thread number folded into range
  function automatic tid_t thread_index(input logic [THREAD_BITS-1:0] thread);
    tid_t t;
    if (THREADS == 1) begin
      t = '0;
    end else if (int'(thread) >= THREADS) begin
      t = tid_t'(int'(thread) - THREADS);
    end else begin
      t = tid_t'(thread);
    end
    return t;
  endfunction

  function automatic hist_t shift_in(input hist_t h, input logic b);
    return {h[HIST_BITS-2:0], b};
  endfunction

endpackage

### rtl/gsh_history.sv
`timescale 1ns / 1ps

module gsh_history (
  input  logic              clk,
  input  logic              rst,
  input  gsh_pkg::tid_t     rd_tid,
  input  logic              rd_odd,
  output gsh_pkg::hist_t    sel,
  output gsh_pkg::hist_t    incl,
  input  gsh_pkg::hist_upd_t upd
);

  gsh_pkg::hist_t hist_excl [gsh_pkg::THREADS];
  gsh_pkg::hist_t hist_incl [gsh_pkg::THREADS];

  // Read side: odd lines see the inclusive history
  assign incl = hist_incl[rd_tid];
  assign sel  = rd_odd ? hist_incl[rd_tid] : hist_excl[rd_tid];

  // Shift, restore and repair
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gsh_pkg::THREADS; i++) begin
        hist_excl[i] <= '0;
        hist_incl[i] <= '0;
      end
    end else if (upd.en) begin
      case (upd.kind)
        gsh_pkg::REQ_SHIFT: begin
          if (!upd.odd) begin
            hist_excl[upd.tid] <= gsh_pkg::shift_in(hist_excl[upd.tid], upd.taken);
          end
          hist_incl[upd.tid] <= gsh_pkg::shift_in(hist_incl[upd.tid], upd.taken);
        end
        gsh_pkg::REQ_RESTORE: begin
          if (upd.sodd) begin
            hist_incl[upd.tid] <= upd.sg;
          end else begin
            hist_excl[upd.tid] <= upd.sg;
            hist_incl[upd.tid] <= upd.sgi;
          end
        end
        gsh_pkg::REQ_REPAIR: begin
          if (upd.odd) begin
            hist_incl[upd.tid] <= gsh_pkg::shift_in(upd.sg, upd.taken);
          end else begin
            hist_excl[upd.tid] <= gsh_pkg::shift_in(upd.sg, upd.taken);
            hist_incl[upd.tid] <= gsh_pkg::shift_in(upd.sgi, upd.taken);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/gsh_ctr_table.sv
`timescale 1ns / 1ps

module gsh_ctr_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  gsh_pkg::hist_t   rd_idx,
  output gsh_pkg::ctr_t    rd_data,
  input  gsh_pkg::ctr_wr_t wr,
  output logic             busy
);

  gsh_pkg::ctr_t  mem [gsh_pkg::TABLE_ENTRIES];
  gsh_pkg::hist_t clr_idx;
  logic           clearing;

  assign busy = clearing;

  // Clear pass after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single write port, registered read with write-through bypass
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      if (wr.en && !clearing && (wr.idx == rd_idx)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_idx];
      end
    end
  end

endmodule

### rtl/gshare_predictor_split_history.sv
`timescale 1ns / 1ps

// Gshare predictor with an exclusive and an inclusive global history per
// thread; bit LINE_SHIFT of the pc picks which one a request uses. One
// request is taken per cycle unless in_stall is high, and each gives
// exactly one result, through the input register, counter table read and
// result register. After reset the counter table is cleared one entry a
// cycle through its single write port; requests are stalled until the clear
// pass ends. Commit updates write back as they leave the table stage and
// are bypassed to a read of the same entry in that cycle.
module gshare_predictor_split_history (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [1:0]  thread,
  input  logic [47:0] pc,
  input  logic        taken,
  input  logic        is_unconditional,
  input  logic [11:0] saved_ghr,
  input  logic [11:0] saved_ghr_inclusive,
  input  logic        saved_odd_set,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        prediction,
  output logic [11:0] snap_ghr,
  output logic [11:0] snap_ghr_inclusive,
  output logic        snap_odd_set
);

  // Stage 1: request register
  logic                     s1_valid;
  gsh_pkg::req_kind_t       s1_kind;
  logic [1:0]               s1_thread;
  logic [47:0]              s1_pc;
  logic                     s1_taken;
  logic                     s1_uncond;
  logic [11:0]              s1_sg;
  logic [11:0]              s1_sgi;
  logic                     s1_sodd;

  // Stage 2: table read
  logic                     s2_valid;
  gsh_pkg::req_kind_t       s2_kind;
  logic                     s2_taken;
  logic                     s2_uncond;
  logic                     s2_odd;
  gsh_pkg::hist_t           s2_sel;
  gsh_pkg::hist_t           s2_incl;
  gsh_pkg::hist_t           s2_idx;

  logic                     adv_out;
  logic                     adv2;
  logic                     adv1;
  logic                     busy;

  gsh_pkg::tid_t            s1_tid;
  logic                     s1_odd;
  gsh_pkg::hist_t           s1_sel;
  gsh_pkg::hist_t           s1_incl;
  gsh_pkg::hist_t           s1_hash;
  gsh_pkg::hist_t           s1_idx;
  gsh_pkg::hist_upd_t       hupd;
  gsh_pkg::ctr_wr_t         cwr;
  gsh_pkg::ctr_t            ctr;

  logic                     res_pred;
  logic                     res_snap;

  // Each stage moves on when the one after it is empty or moving
  assign adv_out  = !out_valid || !out_stall;
  assign adv2     = !s2_valid || adv_out;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = busy || !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_kind   <= gsh_pkg::req_kind_t'(req_type);
      s1_thread <= thread;
      s1_pc     <= pc;
      s1_taken  <= taken;
      s1_uncond <= is_unconditional;
      s1_sg     <= saved_ghr;
      s1_sgi    <= saved_ghr_inclusive;
      s1_sodd   <= saved_odd_set;
    end
  end

  // Stage 1 logic: history select and table index
  assign s1_tid  = gsh_pkg::thread_index(s1_thread);
  assign s1_odd  = s1_pc[gsh_pkg::LINE_SHIFT];
  assign s1_hash = gsh_pkg::HIST_BITS'(s1_pc >> gsh_pkg::INST_SHIFT);
  assign s1_idx  = s1_hash ^ ((s1_kind == gsh_pkg::REQ_COMMIT) ?
                              gsh_pkg::HIST_BITS'(s1_sg) : s1_sel);

  always_comb begin
    hupd.en    = s1_valid && adv2;
    hupd.kind  = s1_kind;
    hupd.tid   = s1_tid;
    hupd.odd   = s1_odd;
    hupd.taken = s1_taken;
    hupd.sg    = gsh_pkg::HIST_BITS'(s1_sg);
    hupd.sgi   = gsh_pkg::HIST_BITS'(s1_sgi);
    hupd.sodd  = s1_sodd;
  end

  gsh_history u_history (
    .clk    (clk),
    .rst    (rst),
    .rd_tid (s1_tid),
    .rd_odd (s1_odd),
    .sel    (s1_sel),
    .incl   (s1_incl),
    .upd    (hupd)
  );

  gsh_ctr_table u_ctr_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s1_valid && adv2),
    .rd_idx  (s1_idx),
    .rd_data (ctr),
    .wr      (cwr),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_kind   <= s1_kind;
      s2_taken  <= s1_taken;
      s2_uncond <= s1_uncond;
      s2_odd    <= s1_odd;
      s2_sel    <= s1_sel;
      s2_incl   <= s1_incl;
      s2_idx    <= s1_idx;
    end
  end

  // Stage 2 logic: prediction and saturating write-back
  always_comb begin
    cwr.en   = s2_valid && adv_out && (s2_kind == gsh_pkg::REQ_COMMIT);
    cwr.idx  = s2_idx;
    cwr.data = ctr;
    if (s2_taken) begin
      if (ctr != gsh_pkg::CTR_MAX) begin
        cwr.data = ctr + 1'b1;
      end
    end else if (ctr != '0) begin
      cwr.data = ctr - 1'b1;
    end
  end

  always_comb begin
    res_pred = 1'b0;
    res_snap = 1'b0;
    case (s2_kind)
      gsh_pkg::REQ_LOOKUP: begin
        res_pred = (ctr > gsh_pkg::CTR_THRESH);
        res_snap = 1'b1;
      end
      gsh_pkg::REQ_SHIFT: begin
        res_pred = s2_uncond;
        res_snap = s2_uncond;
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      prediction         <= res_pred;
      snap_ghr           <= res_snap ? gsh_pkg::SNAP_BITS'(s2_sel) : '0;
      snap_ghr_inclusive <= res_snap ? gsh_pkg::SNAP_BITS'(s2_incl) : '0;
      snap_odd_set       <= res_snap && s2_odd;
    end
  end

`ifndef SYNTHESIS
  // Clear pass holds off requests right after reset
  a_reset_stalls: assert property (@(posedge clk) rst |=> in_stall)
    else $error("request accepted during counter clear");

  // No commit write-back may collide with the clear pass
  a_no_wr_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cwr.en)
    else $error("counter write during clear pass");

  // An accepted request lands in the first stage
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted request lost");

  // A stalled result keeps the second stage from being overwritten
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && out_valid && out_stall |=> s2_valid && $stable(s2_idx))
    else $error("table stage overwritten under stall");
`endif

endmodule

### test/gshare_predictor_split_history_tb.sv
`timescale 1ns / 1ps

module gshare_predictor_split_history_tb;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int DRAIN_CYCLES = 10;
  localparam int POOL_SIZE    = 8;

  // Request codes beyond the defined kinds
  localparam logic [gsh_pkg::REQ_BITS-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [gsh_pkg::REQ_BITS-1:0] REQ_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [gsh_pkg::REQ_BITS-1:0]  kind;
    logic [1:0]                    tid;
    logic [gsh_pkg::PC_BITS-1:0]   pc;
    logic                          tk;
    logic                          uncond;
    logic [gsh_pkg::SNAP_BITS-1:0] sg;
    logic [gsh_pkg::SNAP_BITS-1:0] sgi;
    logic                          sodd;
  } branch_req_t;

  typedef struct packed {
    logic                          pred;
    logic [gsh_pkg::SNAP_BITS-1:0] ghr;
    logic [gsh_pkg::SNAP_BITS-1:0] ghri;
    logic                          odd;
  } branch_rsp_t;

  logic                          clk                 = 1'b0;
  logic                          rst                 = 1'b1;
  logic                          in_valid            = 1'b0;
  logic [2:0]                    req_type            = '0;
  logic [1:0]                    thread              = '0;
  logic [gsh_pkg::PC_BITS-1:0]   pc                  = '0;
  logic                          taken               = 1'b0;
  logic                          is_unconditional    = 1'b0;
  logic [gsh_pkg::SNAP_BITS-1:0] saved_ghr           = '0;
  logic [gsh_pkg::SNAP_BITS-1:0] saved_ghr_inclusive = '0;
  logic                          saved_odd_set       = 1'b0;
  logic                          out_stall           = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic                          prediction;
  logic [gsh_pkg::SNAP_BITS-1:0] snap_ghr;
  logic [gsh_pkg::SNAP_BITS-1:0] snap_ghr_inclusive;
  logic                          snap_odd_set;

  // Predictor state mirrored in the bench
  gsh_pkg::hist_t excl_history [gsh_pkg::THREADS]       = '{default: '0};
  gsh_pkg::hist_t incl_history [gsh_pkg::THREADS]       = '{default: '0};
  gsh_pkg::ctr_t  dir_counters [gsh_pkg::TABLE_ENTRIES] = '{default: '0};

  branch_rsp_t pending_results [$];
  branch_rsp_t head_result;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int total_count    = 0;
  int live_count     = 0;
  int taken_predictions = 0;
  int kind_count [8] = '{default: 0};

  gshare_predictor_split_history dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .req_type            (req_type),
    .thread              (thread),
    .pc                  (pc),
    .taken               (taken),
    .is_unconditional    (is_unconditional),
    .saved_ghr           (saved_ghr),
    .saved_ghr_inclusive (saved_ghr_inclusive),
    .saved_odd_set       (saved_odd_set),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .prediction          (prediction),
    .snap_ghr            (snap_ghr),
    .snap_ghr_inclusive  (snap_ghr_inclusive),
    .snap_odd_set        (snap_odd_set)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("gshare_predictor_split_history: mismatch");
      $finish;
    end
  end

  // Random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Applies one request to the mirrored state and returns its result
  function automatic branch_rsp_t resolve_request(input branch_req_t r);
    branch_rsp_t    rsp;
    gsh_pkg::tid_t  t;
    logic           odd;
    gsh_pkg::hist_t sel;
    gsh_pkg::hist_t idx;
    rsp = '0;
    t   = gsh_pkg::tid_t'(int'(r.tid) % gsh_pkg::THREADS);
    odd = r.pc[gsh_pkg::LINE_SHIFT];
    sel = odd ? incl_history[t] : excl_history[t];
    case (r.kind)
      gsh_pkg::REQ_LOOKUP: begin
        idx = gsh_pkg::hist_t'(r.pc >> gsh_pkg::INST_SHIFT) ^ sel;
        rsp = '{pred: (dir_counters[idx] > gsh_pkg::CTR_THRESH), ghr: sel,
                ghri: incl_history[t], odd: odd};
      end
      gsh_pkg::REQ_SHIFT: begin
        // snapshot is taken before the shift
        if (r.uncond) begin
          rsp = '{pred: 1'b1, ghr: sel, ghri: incl_history[t], odd: odd};
        end
        if (!odd) begin
          excl_history[t] = gsh_pkg::hist_t'({excl_history[t], r.tk});
        end
        incl_history[t] = gsh_pkg::hist_t'({incl_history[t], r.tk});
      end
      gsh_pkg::REQ_RESTORE: begin
        if (r.sodd) begin
          incl_history[t] = gsh_pkg::hist_t'(r.sg);
        end else begin
          excl_history[t] = gsh_pkg::hist_t'(r.sg);
          incl_history[t] = gsh_pkg::hist_t'(r.sgi);
        end
      end
      gsh_pkg::REQ_COMMIT: begin
        idx = gsh_pkg::hist_t'(r.pc >> gsh_pkg::INST_SHIFT) ^ gsh_pkg::hist_t'(r.sg);
        if (r.tk && dir_counters[idx] != gsh_pkg::CTR_MAX) begin
          dir_counters[idx] = dir_counters[idx] + 1'b1;
        end else if (!r.tk && dir_counters[idx] != '0) begin
          dir_counters[idx] = dir_counters[idx] - 1'b1;
        end
      end
      gsh_pkg::REQ_REPAIR: begin
        if (odd) begin
          incl_history[t] = gsh_pkg::hist_t'({r.sg, r.tk});
        end else begin
          excl_history[t] = gsh_pkg::hist_t'({r.sg, r.tk});
          incl_history[t] = gsh_pkg::hist_t'({r.sgi, r.tk});
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic branch_req_t make_req(input logic [gsh_pkg::REQ_BITS-1:0] kind,
                                           input logic [1:0] tid,
                                           input logic [gsh_pkg::PC_BITS-1:0] addr,
                                           input logic tk, input logic uncond,
                                           input logic [gsh_pkg::SNAP_BITS-1:0] sg,
                                           input logic [gsh_pkg::SNAP_BITS-1:0] sgi,
                                           input logic sodd);
    return '{kind: kind, tid: tid, pc: addr, tk: tk, uncond: uncond,
             sg: sg, sgi: sgi, sodd: sodd};
  endfunction

  function automatic branch_req_t random_req();
    return make_req(3'($urandom), 2'($urandom), 48'({$urandom, $urandom}),
                    1'($urandom), 1'($urandom), 12'($urandom), 12'($urandom),
                    1'($urandom));
  endfunction

  // Drives one request and holds it until the transfer
  task automatic send_request(input branch_req_t r, output branch_rsp_t rsp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    req_type            <= r.kind;
    thread              <= r.tid;
    pc                  <= r.pc;
    taken               <= r.tk;
    is_unconditional    <= r.uncond;
    saved_ghr           <= r.sg;
    saved_ghr_inclusive <= r.sgi;
    saved_odd_set       <= r.sodd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rsp = resolve_request(r);
    pending_results.push_back(rsp);
    total_count++;
    kind_count[r.kind]++;
    if (r.kind <= gsh_pkg::REQ_REPAIR) live_count++;
    if (r.kind == gsh_pkg::REQ_LOOKUP && rsp.pred) taken_predictions++;
  endtask

  // Result checker: oldest expectation first
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (prediction !== head_result.pred) begin
          $error("prediction: expected %0d, got %0d", head_result.pred, prediction);
          mismatch_count++;
        end
        if (snap_ghr !== head_result.ghr) begin
          $error("snap_ghr: expected %h, got %h", head_result.ghr, snap_ghr);
          mismatch_count++;
        end
        if (snap_ghr_inclusive !== head_result.ghri) begin
          $error("snap_ghr_inclusive: expected %h, got %h", head_result.ghri,
                 snap_ghr_inclusive);
          mismatch_count++;
        end
        if (snap_odd_set !== head_result.odd) begin
          $error("snap_odd_set: expected %0d, got %0d", head_result.odd, snap_odd_set);
          mismatch_count++;
        end
      end
    end
  end

  // Lookups at the address and field extremes, both line parities
  task automatic test_lookup_extremes();
    branch_rsp_t rsp;
    send_request(make_req(gsh_pkg::REQ_LOOKUP, 2'd0, '0, 1'b0, 1'b0, '0, '0, 1'b0),
                 rsp);
    send_request(make_req(gsh_pkg::REQ_LOOKUP, 2'd3, '1, 1'b1, 1'b1, '1, '1, 1'b1),
                 rsp);
    send_request(make_req(gsh_pkg::REQ_LOOKUP, 2'd1, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b0,
                          12'hAAA, 12'h555, 1'b0), rsp);
    send_request(make_req(gsh_pkg::REQ_LOOKUP, 2'd2, 48'h5555_5555_5555, 1'b0, 1'b1,
                          12'h555, 12'hAAA, 1'b1), rsp);
  endtask

  // Speculative shifts: even lines move both histories, odd only inclusive
  task automatic test_history_shift();
    branch_rsp_t rsp;
    send_request(make_req(gsh_pkg::REQ_SHIFT, 2'd1, 48'h1000, 1'b1, 1'b1, '0, '0, 1'b0),
                 rsp);
    send_request(make_req(gsh_pkg::REQ_SHIFT, 2'd1, 48'h0040, 1'b0, 1'b0, '1, '1, 1'b1),
                 rsp);
    send_request(make_req(gsh_pkg::REQ_SHIFT, 2'd1, 48'h1040, 1'b1, 1'b1, '0, '0, 1'b0),
                 rsp);
    send_request(make_req(gsh_pkg::REQ_LOOKUP, 2'd1, 48'h1000, 1'b0, 1'b0, '0, '0, 1'b0),
                 rsp);
  endtask

  // Counter saturates at the top, predicts taken, then saturates at zero
  task automatic test_counter_saturation();
    branch_rsp_t rsp;
    repeat (4) begin
      send_request(make_req(gsh_pkg::REQ_COMMIT, 2'd2, 48'h2A80, 1'b1, 1'b0, '0, '0,
                            1'b0), rsp);
    end
    send_request(make_req(gsh_pkg::REQ_LOOKUP, 2'd2, 48'h2A80, 1'b0, 1'b0, '0, '0, 1'b0),
                 rsp);
    repeat (4) begin
      send_request(make_req(gsh_pkg::REQ_COMMIT, 2'd2, 48'h2A80, 1'b0, 1'b0, '0, '0,
                            1'b0), rsp);
    end
    send_request(make_req(gsh_pkg::REQ_LOOKUP, 2'd2, 48'h2A80, 1'b1, 1'b0, '0, '0, 1'b0),
                 rsp);
  endtask

  // Squash restore by snapshot flag and repair by line parity
  task automatic test_restore_repair();
    branch_rsp_t rsp;
    send_request(make_req(gsh_pkg::REQ_RESTORE, 2'd3, '0, 1'b0, 1'b0, 12'hFFF, 12'h000,
                          1'b1), rsp);
    send_request(make_req(gsh_pkg::REQ_RESTORE, 2'd3, '1, 1'b1, 1'b1, 12'hAAA, 12'h555,
                          1'b0), rsp);
    send_request(make_req(gsh_pkg::REQ_REPAIR, 2'd3, 48'h0040, 1'b1, 1'b0, 12'hFFF,
                          12'h000, 1'b0), rsp);
    send_request(make_req(gsh_pkg::REQ_REPAIR, 2'd3, 48'h0000, 1'b0, 1'b0, 12'h800,
                          12'h7FF, 1'b1), rsp);
    send_request(make_req(gsh_pkg::REQ_LOOKUP, 2'd3, '1, 1'b0, 1'b0, '0, '0, 1'b0), rsp);
  endtask

  // Unused request codes leave the state alone
  task automatic test_spare_codes();
    branch_req_t r;
    branch_rsp_t rsp;
    for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++) begin
      r      = random_req();
      r.kind = gsh_pkg::REQ_BITS'(k);
      send_request(r, rsp);
    end
  endtask

  // Branch episodes (lookup, speculative shift, recovery, commit) over a
  // small address pool with fixed taken bias, plus random noise
  task automatic test_random_traffic(input int target, input int idle_pct,
                                     input int hold_pct);
    logic [gsh_pkg::PC_BITS-1:0] bpc [POOL_SIZE];
    int                          bias [POOL_SIZE];
    int                          start;
    int                          e;
    logic [1:0]                  tid;
    logic                        outcome;
    branch_rsp_t                 look;
    branch_rsp_t                 rsp;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    for (int i = 0; i < POOL_SIZE; i++) begin
      bpc[i]                      = 48'({$urandom, $urandom});
      bpc[i][gsh_pkg::LINE_SHIFT] = i[0];
      bias[i]                     = (i < 3) ? 100 : (i < 5) ? 90 : 10;
    end
    start = live_count;
    while (live_count - start < target) begin
      if ($urandom_range(99) < 15) begin
        send_request(random_req(), rsp);
      end else begin
        e   = $urandom_range(POOL_SIZE - 1);
        tid = ($urandom_range(99) < 70) ? 2'(e) : 2'($urandom);
        if (e == POOL_SIZE - 1) begin
          // unconditional branch: the shift itself returns the snapshot
          send_request(make_req(gsh_pkg::REQ_SHIFT, tid, bpc[e], 1'b1, 1'b1,
                                12'($urandom), 12'($urandom), 1'($urandom)), rsp);
        end else begin
          outcome = ($urandom_range(99) < bias[e]);
          send_request(make_req(gsh_pkg::REQ_LOOKUP, tid, bpc[e], 1'($urandom),
                                1'($urandom), 12'($urandom), 12'($urandom),
                                1'($urandom)), look);
          send_request(make_req(gsh_pkg::REQ_SHIFT, tid, bpc[e], look.pred, 1'b0,
                                12'($urandom), 12'($urandom), 1'($urandom)), rsp);
          if (look.pred != outcome) begin
            if ($urandom_range(3) == 0) begin
              send_request(make_req(gsh_pkg::REQ_RESTORE, tid, bpc[e], 1'($urandom),
                                    1'b0, look.ghr, look.ghri, look.odd), rsp);
              send_request(make_req(gsh_pkg::REQ_SHIFT, tid, bpc[e], outcome, 1'b0,
                                    '0, '0, 1'b0), rsp);
            end else begin
              send_request(make_req(gsh_pkg::REQ_REPAIR, tid, bpc[e], outcome,
                                    1'($urandom), look.ghr, look.ghri,
                                    1'($urandom)), rsp);
            end
          end
          if ($urandom_range(99) < 85) begin
            send_request(make_req(gsh_pkg::REQ_COMMIT, tid, bpc[e], outcome,
                                  1'($urandom), look.ghr, 12'($urandom),
                                  1'($urandom)), rsp);
          end
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 33;
    stall_pct     = 82;
    test_lookup_extremes();
    test_history_shift();
    test_counter_saturation();
    test_restore_repair();
    test_spare_codes();
    test_random_traffic(460, 33, 82);
    test_random_traffic(460, 82, 33);
    test_random_traffic(460, 0, 0);

    // Drain outstanding results
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d lookups (%0d predicted taken), %0d shifts, %0d restores,",
             total_count, kind_count[gsh_pkg::REQ_LOOKUP], taken_predictions,
             kind_count[gsh_pkg::REQ_SHIFT], kind_count[gsh_pkg::REQ_RESTORE]);
    $display("%0d commits, %0d repairs, %0d unused codes; three idle/stall mixes.",
             kind_count[gsh_pkg::REQ_COMMIT], kind_count[gsh_pkg::REQ_REPAIR],
             total_count - live_count);
    if (mismatch_count == 0) begin
      $display("gshare_predictor_split_history: match");
    end else begin
      $display("gshare_predictor_split_history: mismatch");
    end
    $finish;
  end

endmodule
